// File: rtl/spdg_pkg.sv
// spdg_pkg: shared constants and types for the dense-graph shortest path block
// field widths, register indexes, reset values and the control state type
// no dependencies
package spdg_pkg;

    // default sizing
    localparam int MAX_NODES_DEF   = 64;
    localparam int WEIGHT_BITS_DEF = 16;

    // fixed port field widths
    localparam int VTX_W       = 6;
    localparam int WEIGHT_IN_W = 16;
    localparam int DIST_W      = 22;
    localparam int CNT_W       = 7;
    localparam int CFG_ADDR_W  = 1;
    localparam int CFG_DATA_W  = 7;

    // saturation ceiling for path sums
    localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

    // configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_NODE_COUNT    = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] CFG_SOURCE_VERTEX = 1'b1;

    // configuration reset values
    localparam logic [CNT_W-1:0] NODE_COUNT_RST    = 7'd64;
    localparam logic [VTX_W-1:0] SOURCE_VERTEX_RST = 6'd0;

    // input item actions
    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_RUN   = 1'b1;

    // control sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INIT,
        ST_SCAN,
        ST_SCAN_END,
        ST_MARK,
        ST_RELAX,
        ST_RELAX_END,
        ST_OUT_RD,
        ST_OUT_LD
    } t_state;

endpackage

// File: rtl/shortest_path_dense_graph.sv
// weight write: one transfer per cycle while idle, no result. run: an init pass, then per
// settled vertex a scan pass, a mark step and a relax pass over the weight and node
// memories, a final scan that settles no vertex, then one result per vertex to the sink.
// one item at a time; the node memory port (one read, one write a cycle) sets the pace.
// synchronous active-low reset clears control and config; weights undefined until written.
// depends on spdg_pkg
module shortest_path_dense_graph #(
    parameter int MAX_NODES   = spdg_pkg::MAX_NODES_DEF,
    parameter int WEIGHT_BITS = spdg_pkg::WEIGHT_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration write port
    input  logic                              i_cfg_wen,
    input  logic [spdg_pkg::CFG_ADDR_W-1:0]   i_cfg_addr,
    input  logic [spdg_pkg::CFG_DATA_W-1:0]   i_cfg_wdata,
    // input channel
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic                              i_action,
    input  logic [spdg_pkg::VTX_W-1:0]        i_row,
    input  logic [spdg_pkg::VTX_W-1:0]        i_col,
    input  logic [spdg_pkg::WEIGHT_IN_W-1:0]  i_weight,
    // result channel
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [spdg_pkg::VTX_W-1:0]        o_vertex,
    output logic [spdg_pkg::DIST_W-1:0]       o_distance,
    output logic [spdg_pkg::VTX_W-1:0]        o_predecessor,
    output logic                              o_reachable,
    output logic                              o_last
);

    localparam int NODE_W = $clog2(MAX_NODES);
    localparam int ADDR_W = 2 * NODE_W;
    localparam int WB     = (WEIGHT_BITS < spdg_pkg::WEIGHT_IN_W) ?
                            WEIGHT_BITS : spdg_pkg::WEIGHT_IN_W;
    localparam int DW     = spdg_pkg::DIST_W;
    localparam logic [spdg_pkg::CNT_W-1:0] MAX_CNT = spdg_pkg::CNT_W'(MAX_NODES);

    // per-vertex search state held in the node memory
    typedef struct packed {
        logic [DW-1:0]     best;
        logic              fin;
        logic              vis;
        logic [NODE_W-1:0] prev;
    } t_node;

    // memories
    logic [WB-1:0] w_mem [0:(1 << ADDR_W)-1];
    t_node         node_mem [0:MAX_NODES-1];

    // registers
    spdg_pkg::t_state             r_state, n_state;
    logic [spdg_pkg::CNT_W-1:0]   r_cfg_n;
    logic [spdg_pkg::VTX_W-1:0]   r_cfg_src;
    logic [NODE_W-1:0]            r_idx, n_idx;
    logic [NODE_W-1:0]            r_nlast, n_nlast;
    logic [NODE_W-1:0]            r_src, n_src;
    logic [NODE_W-1:0]            r_u, n_u;
    logic [NODE_W-1:0]            r_u_prev, n_u_prev;
    logic [DW-1:0]                r_min_dist, n_min_dist;
    logic                         r_found, n_found;
    logic                         r_pend, n_pend;
    logic [NODE_W-1:0]            r_pend_idx;
    t_node                        r_node_rd;
    logic [WB-1:0]                r_w_rd;
    logic                         r_out_valid, n_out_valid;
    logic [spdg_pkg::VTX_W-1:0]   r_out_vertex;
    logic [DW-1:0]                r_out_dist;
    logic [spdg_pkg::VTX_W-1:0]   r_out_pred;
    logic                         r_out_reach;
    logic                         r_out_last;

    // combinational controls
    logic                         in_xfer;
    logic                         out_load;
    logic                         w_we;
    logic [ADDR_W-1:0]            w_waddr;
    logic [ADDR_W-1:0]            w_raddr;
    logic                         node_we;
    logic [NODE_W-1:0]            node_waddr;
    t_node                        node_wdata;
    logic [NODE_W-1:0]            node_raddr;
    logic [spdg_pkg::CNT_W-1:0]   n_clamped;
    logic [DW:0]                  relax_sum;
    logic [DW-1:0]                relax_cand;
    logic                         relax_upd;
    logic                         scan_take;

    assign o_in_ready = (r_state == spdg_pkg::ST_IDLE);
    assign in_xfer    = i_in_valid && o_in_ready;

    // node count and source clamped at run start
    always_comb begin
        if (r_cfg_n == '0) begin
            n_clamped = spdg_pkg::CNT_W'(1);
        end else if (r_cfg_n > MAX_CNT) begin
            n_clamped = MAX_CNT;
        end else begin
            n_clamped = r_cfg_n;
        end
    end

    // weight write path, out-of-range rows and columns dropped
    assign w_we    = in_xfer && (i_action == spdg_pkg::ACT_WRITE) &&
                     (spdg_pkg::CNT_W'(i_row) < MAX_CNT) &&
                     (spdg_pkg::CNT_W'(i_col) < MAX_CNT);
    assign w_waddr = {i_row[NODE_W-1:0], i_col[NODE_W-1:0]};
    assign w_raddr = {r_u, r_idx};

    // relaxation of the pending neighbor
    assign relax_sum  = {1'b0, r_min_dist} + (DW + 1)'(r_w_rd);
    assign relax_cand = relax_sum[DW] ? spdg_pkg::DIST_MAX : relax_sum[DW-1:0];
    assign relax_upd  = r_pend && (r_w_rd != '0) && !r_node_rd.vis &&
                        (r_pend_idx != r_u) &&
                        (!r_node_rd.fin || (relax_cand < r_node_rd.best));

    // minimum search over unvisited finite vertices, lowest index wins ties
    assign scan_take  = r_pend && !r_node_rd.vis && r_node_rd.fin &&
                        (!r_found || (r_node_rd.best < r_min_dist));

    // result register loads once the previous result has gone
    assign out_load   = (r_state == spdg_pkg::ST_OUT_LD);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            spdg_pkg::ST_IDLE: begin
                if (in_xfer && (i_action == spdg_pkg::ACT_RUN)) begin
                    n_state = spdg_pkg::ST_INIT;
                end
            end
            spdg_pkg::ST_INIT: begin
                if (r_idx == r_nlast) begin
                    n_state = spdg_pkg::ST_SCAN;
                end
            end
            spdg_pkg::ST_SCAN: begin
                if (r_idx == r_nlast) begin
                    n_state = spdg_pkg::ST_SCAN_END;
                end
            end
            spdg_pkg::ST_SCAN_END: begin
                n_state = spdg_pkg::ST_MARK;
            end
            spdg_pkg::ST_MARK: begin
                n_state = r_found ? spdg_pkg::ST_RELAX : spdg_pkg::ST_OUT_RD;
            end
            spdg_pkg::ST_RELAX: begin
                if (r_idx == r_nlast) begin
                    n_state = spdg_pkg::ST_RELAX_END;
                end
            end
            spdg_pkg::ST_RELAX_END: begin
                n_state = spdg_pkg::ST_SCAN;
            end
            spdg_pkg::ST_OUT_RD: begin
                if (!r_out_valid) begin
                    n_state = spdg_pkg::ST_OUT_LD;
                end
            end
            spdg_pkg::ST_OUT_LD: begin
                n_state = (r_idx == r_nlast) ? spdg_pkg::ST_IDLE : spdg_pkg::ST_OUT_RD;
            end
            default: begin
                n_state = spdg_pkg::ST_IDLE;
            end
        endcase
    end

    // datapath controls and next values
    always_comb begin
        n_idx       = r_idx;
        n_nlast     = r_nlast;
        n_src       = r_src;
        n_u         = r_u;
        n_u_prev    = r_u_prev;
        n_min_dist  = r_min_dist;
        n_found     = r_found;
        n_pend      = 1'b0;
        node_raddr  = r_idx;
        node_we     = 1'b0;
        node_waddr  = r_idx;
        node_wdata  = '0;
        n_out_valid = r_out_valid && !i_out_ready;
        case (r_state)
            spdg_pkg::ST_IDLE: begin
                if (in_xfer && (i_action == spdg_pkg::ACT_RUN)) begin
                    n_idx   = '0;
                    n_found = 1'b0;
                    n_nlast = NODE_W'(n_clamped - spdg_pkg::CNT_W'(1));
                    if (spdg_pkg::CNT_W'(r_cfg_src) >= n_clamped) begin
                        n_src = NODE_W'(n_clamped - spdg_pkg::CNT_W'(1));
                    end else begin
                        n_src = NODE_W'(r_cfg_src);
                    end
                end
            end
            spdg_pkg::ST_INIT: begin
                // distance 0, finite only at the source, predecessor the source
                node_we         = 1'b1;
                node_waddr      = r_idx;
                node_wdata.best = '0;
                node_wdata.fin  = (r_idx == r_src);
                node_wdata.vis  = 1'b0;
                node_wdata.prev = r_src;
                n_idx = (r_idx == r_nlast) ? '0 : r_idx + NODE_W'(1);
            end
            spdg_pkg::ST_SCAN, spdg_pkg::ST_SCAN_END: begin
                if (r_state == spdg_pkg::ST_SCAN) begin
                    n_pend = 1'b1;
                    n_idx  = (r_idx == r_nlast) ? '0 : r_idx + NODE_W'(1);
                end
                if (scan_take) begin
                    n_found    = 1'b1;
                    n_u        = r_pend_idx;
                    n_u_prev   = r_node_rd.prev;
                    n_min_dist = r_node_rd.best;
                end
            end
            spdg_pkg::ST_MARK: begin
                // settle the chosen vertex before its edges are relaxed
                node_we         = r_found;
                node_waddr      = r_u;
                node_wdata.best = r_min_dist;
                node_wdata.fin  = 1'b1;
                node_wdata.vis  = 1'b1;
                node_wdata.prev = r_u_prev;
                n_found         = 1'b0;
                n_idx           = '0;
            end
            spdg_pkg::ST_RELAX, spdg_pkg::ST_RELAX_END: begin
                if (r_state == spdg_pkg::ST_RELAX) begin
                    n_pend = 1'b1;
                    n_idx  = (r_idx == r_nlast) ? '0 : r_idx + NODE_W'(1);
                end
                node_we         = relax_upd;
                node_waddr      = r_pend_idx;
                node_wdata.best = relax_cand;
                node_wdata.fin  = 1'b1;
                node_wdata.vis  = 1'b0;
                node_wdata.prev = r_u;
            end
            spdg_pkg::ST_OUT_RD: begin
                n_pend = !r_out_valid;
            end
            spdg_pkg::ST_OUT_LD: begin
                n_out_valid = 1'b1;
                n_idx = (r_idx == r_nlast) ? '0 : r_idx + NODE_W'(1);
            end
            default: begin
                n_pend = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= spdg_pkg::ST_IDLE;
            r_cfg_n     <= spdg_pkg::NODE_COUNT_RST;
            r_cfg_src   <= spdg_pkg::SOURCE_VERTEX_RST;
            r_idx       <= '0;
            r_nlast     <= '0;
            r_src       <= '0;
            r_found     <= 1'b0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_nlast     <= n_nlast;
            r_src       <= n_src;
            r_found     <= n_found;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
            if (i_cfg_wen) begin
                case (i_cfg_addr)
                    spdg_pkg::CFG_NODE_COUNT: begin
                        r_cfg_n <= i_cfg_wdata;
                    end
                    spdg_pkg::CFG_SOURCE_VERTEX: begin
                        r_cfg_src <= i_cfg_wdata[spdg_pkg::VTX_W-1:0];
                    end
                    default: begin
                        r_cfg_n <= r_cfg_n;
                    end
                endcase
            end
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        r_u        <= n_u;
        r_u_prev   <= n_u_prev;
        r_min_dist <= n_min_dist;
        r_pend_idx <= r_idx;
    end

    // weight memory, registered read
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            w_mem[w_waddr] <= i_weight[WB-1:0];
        end
        r_w_rd <= w_mem[w_raddr];
    end

    // node memory, registered read
    always_ff @(posedge i_clk) begin
        if (node_we) begin
            node_mem[node_waddr] <= node_wdata;
        end
        r_node_rd <= node_mem[node_raddr];
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_vertex <= spdg_pkg::VTX_W'(r_pend_idx);
            r_out_dist   <= r_node_rd.fin ? r_node_rd.best : '0;
            r_out_pred   <= spdg_pkg::VTX_W'(r_node_rd.prev);
            r_out_reach  <= r_node_rd.fin;
            r_out_last   <= (r_pend_idx == r_nlast);
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_vertex      = r_out_vertex;
    assign o_distance    = r_out_dist;
    assign o_predecessor = r_out_pred;
    assign o_reachable   = r_out_reach;
    assign o_last        = r_out_last;

endmodule
